FILE: hdl/hill3_pkg.sv
package hill3_pkg;

   localparam int unsigned Modulus      = 26;
   localparam int unsigned UpperBase    = 65;
   localparam int unsigned LowerBase    = 97;
   localparam int unsigned LetterOffset = 10 * Modulus - UpperBase;
   localparam int unsigned Recip        = 2521;
   localparam int unsigned RecipShift   = 16;

   localparam logic [1:0] CsrKeyRowZero = 2'd0;
   localparam logic [1:0] CsrKeyRowOne  = 2'd1;
   localparam logic [1:0] CsrKeyRowTwo  = 2'd2;

   typedef logic [4:0] letter_type;
   typedef letter_type [2:0] vec_type;
   typedef vec_type [2:0] mat_type;

   typedef struct packed {
      logic       flag;
      letter_type inv;
   } det_inv_type;

   // x mod 26 for x below 2048: multiply by a scaled reciprocal, exact in that range
   function automatic letter_type mod26(input logic [10:0] x);
      logic [22:0] prod;
      logic [6:0]  quo;
      logic [10:0] rem;
      prod = {12'b0, x} * 23'(Recip);
      quo  = prod[22:RecipShift];
      rem  = x - 11'({4'b0, quo} * 11'(Modulus));
      return rem[4:0];
   endfunction

   // (a*b - c*d) mod 26, operands in 0..25
   function automatic letter_type cross_mod(input letter_type a, input letter_type b,
                                            input letter_type c, input letter_type d);
      logic [9:0]  ab;
      logic [9:0]  cd;
      logic [10:0] sum;
      ab  = {5'b0, a} * {5'b0, b};
      cd  = {5'b0, c} * {5'b0, d};
      sum = {1'b0, ab} + 11'(Modulus * Modulus) - {1'b0, cd};
      return mod26(sum);
   endfunction

   function automatic letter_type neg_mod(input letter_type x);
      return (x == 5'd0) ? 5'd0 : 5'(Modulus) - x;
   endfunction

   // inverse of the determinant mod 26; no inverse gives 25 and the flag
   function automatic det_inv_type det_inverse(input letter_type det);
      det_inv_type res;
      res.flag = 1'b0;
      res.inv  = 5'd25;
      case (det)
         5'd1:  res.inv = 5'd1;
         5'd3:  res.inv = 5'd9;
         5'd5:  res.inv = 5'd21;
         5'd7:  res.inv = 5'd15;
         5'd9:  res.inv = 5'd3;
         5'd11: res.inv = 5'd19;
         5'd15: res.inv = 5'd7;
         5'd17: res.inv = 5'd23;
         5'd19: res.inv = 5'd11;
         5'd21: res.inv = 5'd5;
         5'd23: res.inv = 5'd17;
         5'd25: res.inv = 5'd25;
         default: res.flag = 1'b1;
      endcase
      return res;
   endfunction

endpackage

FILE: hdl/hill_cipher_3x3_mod26_core.sv
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   mode, three characters
// rsp       out        rsp_valid / rsp_stall   three characters, key_not_invertible
// csr       in         csr_valid / csr_ready   2-bit register index, 15-bit key row
//
// Five register stages; one block enters per cycle except while a result is held on rsp.
// Each result leaves from stage five. The depth is set by the decrypt path: adjugate,
// determinant and its inverse, inverse key, then the final vector-matrix product.
// Synchronous active-high reset clears the stage valid bits and the key rows.
// A stall on rsp over a valid result holds every stage in place and is passed back to req.
module hill_cipher_3x3_mod26_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_char_first,
   input  logic [7:0]  req_char_second,
   input  logic [7:0]  req_char_third,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_first,
   output logic [7:0]  rsp_out_second,
   output logic [7:0]  rsp_out_third,
   output logic        rsp_key_not_invertible,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_data
);
   import hill3_pkg::*;

   // key rows
   logic [14:0] key0_ff, key1_ff, key2_ff;

   // pipeline control: the whole pipe moves together
   logic advance;
   logic [5:1] valid_ff, valid_in;

   // stage 1: letter values and reduced key
   vec_type     s1_p_ff, s1_p_in;
   mat_type     s1_k_ff, s1_k_in;
   logic        s1_mode_ff;
   // stage 2: adjugate
   vec_type     s2_p_ff;
   mat_type     s2_k_ff, s2_adj_ff, s2_adj_in;
   logic        s2_mode_ff;
   // stage 3: determinant inverse
   vec_type     s3_p_ff;
   mat_type     s3_k_ff, s3_adj_ff;
   det_inv_type s3_det_ff, s3_det_in;
   logic        s3_mode_ff;
   // stage 4: key actually applied
   vec_type     s4_p_ff;
   mat_type     s4_m_ff, s4_m_in;
   logic        s4_flag_ff;
   logic        s4_mode_ff;
   // stage 5: output register
   logic [7:0]  s5_out_ff [3];
   logic [7:0]  s5_out_in [3];
   logic        s5_flag_ff;

   // hold everything while the output is stalled
   assign advance   = !(valid_ff[5] && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // key writes; an index beyond the key rows is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0;
         key1_ff <= '0;
         key2_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrKeyRowZero: key0_ff <= csr_data;
            CsrKeyRowOne:  key1_ff <= csr_data;
            CsrKeyRowTwo:  key2_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign valid_in = {valid_ff[4:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: character codes to letter values, key entries taken mod 26
   always_comb begin
      s1_p_in[0] = mod26(11'({3'b0, req_char_first})  + 11'(LetterOffset));
      s1_p_in[1] = mod26(11'({3'b0, req_char_second}) + 11'(LetterOffset));
      s1_p_in[2] = mod26(11'({3'b0, req_char_third})  + 11'(LetterOffset));
      for (int c = 0; c < 3; c++) begin
         s1_k_in[0][c] = mod26({6'b0, key0_ff[5*c +: 5]});
         s1_k_in[1][c] = mod26({6'b0, key1_ff[5*c +: 5]});
         s1_k_in[2][c] = mod26({6'b0, key2_ff[5*c +: 5]});
      end
   end

   // stage 2: adjugate of the key, mod 26
   always_comb begin
      s2_adj_in[0][0] = cross_mod(s1_k_ff[1][1], s1_k_ff[2][2], s1_k_ff[1][2], s1_k_ff[2][1]);
      s2_adj_in[1][0] = neg_mod(cross_mod(s1_k_ff[1][0], s1_k_ff[2][2],
                                          s1_k_ff[1][2], s1_k_ff[2][0]));
      s2_adj_in[2][0] = cross_mod(s1_k_ff[1][0], s1_k_ff[2][1], s1_k_ff[1][1], s1_k_ff[2][0]);
      s2_adj_in[0][1] = neg_mod(cross_mod(s1_k_ff[0][1], s1_k_ff[2][2],
                                          s1_k_ff[0][2], s1_k_ff[2][1]));
      s2_adj_in[1][1] = cross_mod(s1_k_ff[0][0], s1_k_ff[2][2], s1_k_ff[0][2], s1_k_ff[2][0]);
      s2_adj_in[2][1] = neg_mod(cross_mod(s1_k_ff[0][0], s1_k_ff[2][1],
                                          s1_k_ff[0][1], s1_k_ff[2][0]));
      s2_adj_in[0][2] = cross_mod(s1_k_ff[0][1], s1_k_ff[1][2], s1_k_ff[0][2], s1_k_ff[1][1]);
      s2_adj_in[1][2] = neg_mod(cross_mod(s1_k_ff[0][0], s1_k_ff[1][2],
                                          s1_k_ff[0][2], s1_k_ff[1][0]));
      s2_adj_in[2][2] = cross_mod(s1_k_ff[0][0], s1_k_ff[1][1], s1_k_ff[0][1], s1_k_ff[1][0]);
   end

   // stage 3: determinant by the first row against the adjugate's first column
   always_comb begin
      logic [10:0] det_sum;
      det_sum = '0;
      for (int i = 0; i < 3; i++) begin
         det_sum = det_sum + 11'({5'b0, s2_k_ff[0][i]} * {5'b0, s2_adj_ff[i][0]});
      end
      s3_det_in = det_inverse(mod26(det_sum));
   end

   // stage 4: encrypt uses the key, decrypt the inverse key
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            s4_m_in[r][c] = s3_mode_ff ? mod26({1'b0, {5'b0, s3_det_ff.inv} *
                                                      {5'b0, s3_adj_ff[r][c]}})
                                       : s3_k_ff[r][c];
         end
      end
   end

   // stage 5: row vector times matrix, then letter base
   always_comb begin
      logic [10:0] acc;
      logic [7:0]  base;
      base = s4_mode_ff ? 8'(LowerBase) : 8'(UpperBase);
      for (int c = 0; c < 3; c++) begin
         acc = '0;
         for (int r = 0; r < 3; r++) begin
            acc = acc + 11'({5'b0, s4_p_ff[r]} * {5'b0, s4_m_ff[r][c]});
         end
         s5_out_in[c] = base + {3'b0, mod26(acc)};
      end
   end

   // payload registers: no reset, move only with the pipe
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_p_ff    <= s1_p_in;
         s1_k_ff    <= s1_k_in;
         s1_mode_ff <= req_mode;

         s2_p_ff    <= s1_p_ff;
         s2_k_ff    <= s1_k_ff;
         s2_adj_ff  <= s2_adj_in;
         s2_mode_ff <= s1_mode_ff;

         s3_p_ff    <= s2_p_ff;
         s3_k_ff    <= s2_k_ff;
         s3_adj_ff  <= s2_adj_ff;
         s3_det_ff  <= s3_det_in;
         s3_mode_ff <= s2_mode_ff;

         s4_p_ff    <= s3_p_ff;
         s4_m_ff    <= s4_m_in;
         s4_flag_ff <= s3_mode_ff & s3_det_ff.flag;
         s4_mode_ff <= s3_mode_ff;

         s5_out_ff  <= s5_out_in;
         s5_flag_ff <= s4_flag_ff;
      end
   end

   assign rsp_valid              = valid_ff[5];
   assign rsp_out_first          = s5_out_ff[0];
   assign rsp_out_second         = s5_out_ff[1];
   assign rsp_out_third          = s5_out_ff[2];
   assign rsp_key_not_invertible = s5_flag_ff;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the 3x3 mod-26 Hill cipher core.
module tb_top;
   import hill3_pkg::*;

   // block modes on req_mode
   localparam logic ModeEncrypt = 1'b0;
   localparam logic ModeDecrypt = 1'b1;

   // index past the last key row; the core must drop writes to it
   localparam logic [1:0] CsrUnused = 2'd3;

   // named key settings used by the directed table
   localparam logic [2:0] KeyZero     = 3'd0;
   localparam logic [2:0] KeyClassic  = 3'd1;
   localparam logic [2:0] KeyAllOnes  = 3'd2;
   localparam logic [2:0] KeyAllMax   = 3'd3;
   localparam logic [2:0] KeyDoubled  = 3'd4;
   localparam logic [2:0] KeyThirteen = 3'd5;
   localparam logic [2:0] KeyIdentity = 3'd6;

   localparam int Radix  = int'(Modulus);
   localparam int UpperA = int'(UpperBase);
   localparam int LowerA = int'(LowerBase);

   localparam int ResultLatency  = 5;
   localparam int SettleCycles   = ResultLatency + 3;
   localparam int IdleLimit      = 2000;
   localparam int RandomPhases   = 8;
   localparam int BlocksPerPhase = 75;
   localparam int MaxReports     = 10;

   typedef struct packed {
      logic [7:0] out_first;
      logic [7:0] out_second;
      logic [7:0] out_third;
      logic       key_not_invertible;
   } cipher_block_type;

   typedef struct packed {
      logic [2:0]       key_set;
      logic             mode;
      logic [7:0]       char_first;
      logic [7:0]       char_second;
      logic [7:0]       char_third;
      logic             known;
      cipher_block_type want;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_mode;
   logic [7:0]  req_char_first;
   logic [7:0]  req_char_second;
   logic [7:0]  req_char_third;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_first;
   logic [7:0]  rsp_out_second;
   logic [7:0]  rsp_out_third;
   logic        rsp_key_not_invertible;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [14:0] csr_data;

   // key rows as the core should hold them, tracked from csr transfers
   logic [14:0]      key_model [3];
   // blocks expected on rsp, oldest first
   cipher_block_type pending_blocks [$];
   directed_row_type directed_rows [$];
   // hand-typed expectation for the block currently on req
   logic             typed_active;
   cipher_block_type typed_block;
   int               fail_count;
   int               sender_calm;

   hill_cipher_3x3_mod26_core DUT (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Mostly no gap or a short one, now and then a long one.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Work out the three output characters and the flag for one block under the
   // given key rows.
   function automatic cipher_block_type predict_cipher_block(
         input logic mode, input logic [7:0] ch0, input logic [7:0] ch1,
         input logic [7:0] ch2, input logic [14:0] row0, input logic [14:0] row1,
         input logic [14:0] row2);
      logic [14:0]      rows [3];
      logic [7:0]       codes [3];
      logic [7:0]       outs [3];
      int               key [3][3];
      int               adj [3][3];
      int               mat [3][3];
      int               plain [3];
      int               ra, rb, ca, cb, minor, det, inv, acc, base;
      logic             singular;
      cipher_block_type res;
      rows[0]  = row0;
      rows[1]  = row1;
      rows[2]  = row2;
      codes[0] = ch0;
      codes[1] = ch1;
      codes[2] = ch2;
      for (int r = 0; r < 3; r++) begin
         plain[r] = ((int'(codes[r]) - UpperA) % Radix + Radix) % Radix;
         for (int c = 0; c < 3; c++)
            key[r][c] = int'((rows[r] >> (5 * c)) & 15'h1f) % Radix;
      end
      // adjugate: transposed cofactors, sign by checkerboard
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            ra    = (c == 0) ? 1 : 0;
            rb    = (c == 2) ? 1 : 2;
            ca    = (r == 0) ? 1 : 0;
            cb    = (r == 2) ? 1 : 2;
            minor = key[ra][ca] * key[rb][cb] - key[ra][cb] * key[rb][ca];
            if ((r + c) % 2 == 1)
               minor = -minor;
            adj[r][c] = (minor % Radix + Radix) % Radix;
         end
      end
      det = (key[0][0] * adj[0][0] + key[0][1] * adj[1][0] + key[0][2] * adj[2][0]) % Radix;
      // no inverse leaves -1, so the inverse key is the negated adjugate
      singular = 1'b1;
      inv      = Radix - 1;
      for (int i = 1; i < Radix; i++) begin
         if (singular && (i * det) % Radix == 1) begin
            inv      = i;
            singular = 1'b0;
         end
      end
      if (mode == ModeEncrypt) begin
         singular = 1'b0;
         base     = UpperA;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               mat[r][c] = key[r][c];
      end else begin
         base = LowerA;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               mat[r][c] = (inv * adj[r][c]) % Radix;
      end
      for (int c = 0; c < 3; c++) begin
         acc     = plain[0] * mat[0][c] + plain[1] * mat[1][c] + plain[2] * mat[2][c];
         outs[c] = 8'(base + acc % Radix);
      end
      res.out_first          = outs[0];
      res.out_second         = outs[1];
      res.out_third          = outs[2];
      res.key_not_invertible = singular;
      return res;
   endfunction

   // Key rows of a named setting, packed {row two, row one, row zero}.
   function automatic logic [44:0] key_set_rows(input logic [2:0] sel);
      case (sel)
         KeyClassic:  return {{5'd15, 5'd17, 5'd20}, {5'd10, 5'd16, 5'd13},
                              {5'd1, 5'd24, 5'd6}};
         KeyAllOnes:  return {3{15'h7fff}};
         KeyAllMax:   return {3{5'd25, 5'd25, 5'd25}};
         KeyDoubled:  return {{5'd2, 5'd0, 5'd0}, {5'd0, 5'd2, 5'd0}, {5'd0, 5'd0, 5'd2}};
         KeyThirteen: return {{5'd1, 5'd0, 5'd0}, {5'd0, 5'd1, 5'd0}, {5'd0, 5'd0, 5'd13}};
         KeyIdentity: return {{5'd1, 5'd0, 5'd0}, {5'd0, 5'd1, 5'd0}, {5'd0, 5'd0, 5'd1}};
         default:     return '0;
      endcase
   endfunction

   // Raw 15-bit row, or three entries kept within 0..25.
   function automatic logic [14:0] random_key_row(input bit raw);
      if (raw)
         return 15'($urandom_range(0, 32767));
      return {5'($urandom_range(0, 25)), 5'($urandom_range(0, 25)),
              5'($urandom_range(0, 25))};
   endfunction

   // Mostly uppercase letters, some lowercase, some arbitrary bytes.
   function automatic logic [7:0] random_char();
      case ($urandom_range(0, 3))
         0, 1:    return 8'(UpperA + $urandom_range(0, 25));
         2:       return 8'(LowerA + $urandom_range(0, 25));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_row(input logic [2:0] key_set, input logic mode, input logic [7:0] c0,
                          input logic [7:0] c1, input logic [7:0] c2, input logic known,
                          input cipher_block_type want);
      directed_rows.insert(directed_rows.size(), {key_set, mode, c0, c1, c2, known, want});
   endtask

   // One csr transfer; leaves csr_valid high for a back-to-back write.
   task automatic write_csr(input logic [1:0] index, input logic [14:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Drain the pipe, then load all three key rows. Waiting for every expected
   // block before the writes is also the sender pause.
   task automatic load_key(input logic [44:0] rows, input bit poke_unused);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_blocks.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      write_csr(CsrKeyRowZero, rows[14:0]);
      write_csr(CsrKeyRowOne, rows[29:15]);
      write_csr(CsrKeyRowTwo, rows[44:30]);
      if (poke_unused)
         write_csr(CsrUnused, 15'($urandom_range(0, 32767)));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offer one block on req after an optional gap and hold it until the transfer.
   task automatic send_block(input logic mode, input logic [7:0] c0, input logic [7:0] c1,
                             input logic [7:0] c2, input logic known,
                             input cipher_block_type want);
      int gap;
      if (sender_calm > 0) begin
         gap = 0;
         sender_calm--;
      end else begin
         gap = gap_length();
         if ($urandom_range(0, 19) == 0)
            sender_calm = $urandom_range(20, 40);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_char_first  <= c0;
      req_char_second <= c1;
      req_char_third  <= c2;
      typed_active    <= known;
      typed_block     <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // Receiver: runs of open cycles broken by stalls, sometimes a long open stretch.
   initial begin : rsp_backpressure
      int open_len;
      int stall_len;
      rsp_stall = 1'b0;
      forever begin
         open_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 6);
         stall_len = gap_length();
         repeat (open_len) @(negedge clock) rsp_stall <= 1'b0;
         repeat (stall_len) @(negedge clock) rsp_stall <= 1'b1;
      end
   end

   // Track key writes, queue an expectation per req transfer, check each rsp
   // transfer against the oldest one.
   always @(posedge clock) begin : scoreboard
      cipher_block_type want;
      cipher_block_type got;
      if (reset) begin
         for (int r = 0; r < 3; r++)
            key_model[r] = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrKeyRowZero: key_model[0] = csr_data;
               CsrKeyRowOne:  key_model[1] = csr_data;
               CsrKeyRowTwo:  key_model[2] = csr_data;
               default: ;   // drop writes past the key rows
            endcase
         end
         if (req_valid && !req_stall) begin
            if (typed_active)
               pending_blocks.insert(pending_blocks.size(), typed_block);
            else
               pending_blocks.insert(pending_blocks.size(),
                  predict_cipher_block(req_mode, req_char_first, req_char_second,
                     req_char_third, key_model[0], key_model[1], key_model[2]));
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_first, rsp_out_second, rsp_out_third, rsp_key_not_invertible};
            if (pending_blocks.size() == 0) begin
               fail_count++;
               if (fail_count <= MaxReports)
                  $display("ERROR %0t: unexpected result %h %h %h flag %b", $realtime,
                           got.out_first, got.out_second, got.out_third,
                           got.key_not_invertible);
            end else begin
               want = pending_blocks.pop_front();
               if (got.out_first !== want.out_first || got.out_second !== want.out_second ||
                   got.out_third !== want.out_third ||
                   got.key_not_invertible !== want.key_not_invertible) begin
                  fail_count++;
                  if (fail_count <= MaxReports)
                     $display("ERROR %0t: expected %h %h %h flag %b, got %h %h %h flag %b",
                              $realtime, want.out_first, want.out_second, want.out_third,
                              want.key_not_invertible, got.out_first, got.out_second,
                              got.out_third, got.key_not_invertible);
               end
            end
         end
      end
   end

   // Abort when no transfer of any kind happens for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("hill_cipher_3x3_mod26_core verification failed");
      $finish;
   end

   initial begin : stimulus
      directed_row_type row;
      int               active_set;
      bit               raw_key;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = ModeEncrypt;
      req_char_first  = '0;
      req_char_second = '0;
      req_char_third  = '0;
      csr_valid       = 1'b0;
      csr_index       = CsrKeyRowZero;
      csr_data        = '0;
      typed_active    = 1'b0;
      typed_block     = '0;
      fail_count      = 0;
      sender_calm     = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero key: encrypt gives all 'A', decrypt has no inverse and gives all 'a'
      add_row(KeyZero, ModeEncrypt, "A", "B", "C", 1'b1, {"AAA", 1'b0});
      add_row(KeyZero, ModeDecrypt, "X", "Y", "Z", 1'b1, {"aaa", 1'b1});
      add_row(KeyZero, ModeEncrypt, 8'h00, 8'hff, 8'h7f, 1'b1, {"AAA", 1'b0});
      add_row(KeyZero, ModeDecrypt, 8'hff, 8'h00, 8'h80, 1'b1, {"aaa", 1'b1});
      // textbook key, determinant invertible
      add_row(KeyClassic, ModeEncrypt, "A", "C", "T", 1'b0, '0);
      add_row(KeyClassic, ModeEncrypt, "A", "A", "A", 1'b1, {"AAA", 1'b0});
      add_row(KeyClassic, ModeEncrypt, "Z", "Z", "Z", 1'b0, '0);
      add_row(KeyClassic, ModeDecrypt, "P", "O", "H", 1'b0, '0);
      add_row(KeyClassic, ModeEncrypt, "a", "z", "{", 1'b0, '0);
      add_row(KeyClassic, ModeDecrypt, 8'hff, 8'hfe, 8'h00, 1'b0, '0);
      add_row(KeyClassic, ModeEncrypt, 8'h00, 8'h01, 8'h40, 1'b0, '0);
      // entries above 25 wrap; all-equal rows leave a zero adjugate
      add_row(KeyAllOnes, ModeDecrypt, "A", "B", "C", 1'b1, {"aaa", 1'b1});
      add_row(KeyAllOnes, ModeEncrypt, "B", "C", "D", 1'b0, '0);
      add_row(KeyAllOnes, ModeEncrypt, 8'hff, 8'hff, 8'hff, 1'b0, '0);
      add_row(KeyAllMax, ModeDecrypt, 8'hff, 8'h80, 8'h01, 1'b1, {"aaa", 1'b1});
      add_row(KeyAllMax, ModeEncrypt, "Z", "Z", "Z", 1'b0, '0);
      // even determinant and determinant 13: no inverse, nonzero adjugate
      add_row(KeyDoubled, ModeDecrypt, "B", "C", "D", 1'b0, '0);
      add_row(KeyDoubled, ModeEncrypt, "B", "C", "D", 1'b0, '0);
      add_row(KeyThirteen, ModeDecrypt, "X", "Y", "Z", 1'b0, '0);
      add_row(KeyThirteen, ModeEncrypt, "X", "Y", "Z", 1'b0, '0);
      // identity key decrypts to the same letters in lowercase
      add_row(KeyIdentity, ModeDecrypt, "H", "E", "Y", 1'b1, {"hey", 1'b0});
      add_row(KeyIdentity, ModeEncrypt, "h", "e", "y", 1'b0, '0);

      active_set = -1;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (int'(row.key_set) != active_set) begin
            // identity load also pokes the unused index, which must not disturb the key
            load_key(key_set_rows(row.key_set), row.key_set == KeyIdentity);
            active_set = int'(row.key_set);
         end
         send_block(row.mode, row.char_first, row.char_second, row.char_third, row.known,
                    row.want);
      end

      // random phases, a fresh key for each
      for (int phase = 0; phase < RandomPhases; phase++) begin
         raw_key = ($urandom_range(0, 1) == 1);
         load_key({random_key_row(raw_key), random_key_row(raw_key), random_key_row(raw_key)},
                  phase % 3 == 0);
         repeat (BlocksPerPhase)
            send_block(1'($urandom_range(0, 1)), random_char(), random_char(), random_char(),
                       1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_blocks.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0 && pending_blocks.size() == 0)
         $display("hill_cipher_3x3_mod26_core verification clean");
      else
         $display("hill_cipher_3x3_mod26_core verification failed");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/hill3_pkg.sv
hdl/hill_cipher_3x3_mod26_core.sv
sim/tb_top.sv
